>>> src/satp_pkg.sv
// Package for the SAT solution text parser: item and result types, parser phases,
// character classes, error codes and keyword tables.
// Used by every module under src; depends on nothing.
`default_nettype none

package satp_pkg;

   localparam int LITERAL_BITS_DEF = 31;
   localparam int LINE_BITS_DEF    = 16;
   localparam int ITEM_DEPTH       = 2;
   localparam int RSP_DEPTH        = 4;

   localparam logic [3:0] KW_SAT_LEN   = 4'd11;
   localparam logic [3:0] KW_KNOWN_LEN = 4'd5;

   typedef enum logic [2:0] {
      CLS_EOF,
      CLS_NEWLINE,
      CLS_SPACE,
      CLS_TAB,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } cls_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_COMMENT,
      PH_S_SPACE,
      PH_S_WORD,
      PH_U_N,
      PH_UN_X,
      PH_KW_SAT,
      PH_KW_KNOWN,
      PH_KW_UNSAT,
      PH_V_START,
      PH_BLANKS,
      PH_MINUS,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      KIND_LITERAL,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_BAD_LINE_START,
      ERR_NO_SOLUTION,
      ERR_INVALID_SOLUTION,
      ERR_NOT_SATISFIABLE,
      ERR_MISSING_ZERO,
      ERR_EXPECTED_LITERAL,
      ERR_OVERFLOW
   } err_type;

   typedef struct packed {
      cls_type     cls;
      logic [7:0]  char_byte;
      logic [15:0] line_number;
   } item_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] literal_value;
      err_type            error_code;
      logic [15:0]        line_number;
      logic               last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } rsp_wr_type;

   function automatic logic [7:0] kw_char(input logic known, input logic [3:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (known) begin
         case (pos)
            4'd0:    c = "N";
            4'd1:    c = "O";
            4'd2:    c = "W";
            4'd3:    c = "N";
            4'd4:    c = "\n";
            default: c = 8'h00;
         endcase
      end else begin
         case (pos)
            4'd0:    c = "A";
            4'd1:    c = "T";
            4'd2:    c = "I";
            4'd3:    c = "S";
            4'd4:    c = "F";
            4'd5:    c = "I";
            4'd6:    c = "A";
            4'd7:    c = "B";
            4'd8:    c = "L";
            4'd9:    c = "E";
            4'd10:   c = "\n";
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

   function automatic result_type mk_result(input kind_type kind,
                                            input logic signed [31:0] lit,
                                            input err_type code,
                                            input logic [15:0] line,
                                            input logic last);
      result_type r;
      r.kind          = kind;
      r.literal_value = lit;
      r.error_code    = code;
      r.line_number   = line;
      r.last_of_run   = last;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/sat_solution_text_parser_core.sv
// Streaming parser for a SAT solver answer: one character per transaction in, literals,
// a done mark or one parse error out. Takes one character every clock while results
// drain; the first result for a character passes through the item queue, then the parser
// writes it into the result queue. A character that yields two results has them handed
// out one at a time through the single read port of the result queue. After done or an
// error, further characters are taken and dropped until reset.
// Depends on satp_pkg, satp_front, satp_item_queue, satp_back and satp_rsp_queue.
`default_nettype none

module sat_solution_text_parser_core
   import satp_pkg::*;
#(
   parameter int LITERAL_BITS = LITERAL_BITS_DEF,
   parameter int LINE_BITS    = LINE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_char_byte,
   input  wire logic               req_end_of_file,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic signed [31:0]      rsp_literal_value,
   output logic [2:0]              rsp_error_code,
   output logic [15:0]             rsp_line_number,
   output logic                    rsp_last_of_run
);

   logic                              q_full, q_not_empty, q_pop, accept;
   item_type                          front_item, q_head;
   rsp_wr_type                        rsp_wr;
   logic                              rsp_room, rsp_pop;
   logic [$clog2(RSP_DEPTH+1)-1:0]    rsp_count;
   result_type                        rsp_head;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   satp_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_char_byte),
      .end_of_file (req_end_of_file),
      .item        (front_item)
   );

   satp_item_queue u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   satp_back #(
      .LITERAL_BITS (LITERAL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (q_head),
      .room       (rsp_room),
      .pop        (q_pop),
      .wr         (rsp_wr)
   );

   satp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (rsp_wr),
      .pop       (rsp_pop),
      .room      (rsp_room),
      .not_empty (rsp_valid),
      .count     (rsp_count),
      .head      (rsp_head)
   );

   assign rsp_pop           = rsp_valid && !rsp_stall;
   assign rsp_kind          = rsp_head.kind;
   assign rsp_literal_value = rsp_head.literal_value;
   assign rsp_error_code    = rsp_head.error_code;
   assign rsp_line_number   = rsp_head.line_number;
   assign rsp_last_of_run   = rsp_head.last_of_run;

   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= ($clog2(RSP_DEPTH+1))'(RSP_DEPTH))
      else $error("result queue overrun");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_LITERAL |-> rsp_last_of_run)
      else $error("done or error result not last of its run");

   a_literal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LITERAL |-> rsp_literal_value != 32'sd0)
      else $error("zero literal reported");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      rsp_wr.count != 2'd0 |-> $past(rsp_count) <= ($clog2(RSP_DEPTH+1))'(RSP_DEPTH)
                               && q_pop)
      else $error("result written without a parsed character");

endmodule

`default_nettype wire

>>> src/satp_front.sv
// Front end: takes characters, classifies them and tags each with its line number.
// Depends on satp_pkg.
`default_nettype none

module satp_front
   import satp_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] char_byte,
   input  wire logic       end_of_file,
   output item_type        item
);

   localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 prev_nl_ff, prev_nl_in;
   logic [LW-1:0]        line_ext;
   cls_type              cls;

   always_comb begin
      cls = CLS_OTHER;
      if (end_of_file) begin
         cls = CLS_EOF;
      end else begin
         case (char_byte)
            "\n":    cls = CLS_NEWLINE;
            " ":     cls = CLS_SPACE;
            "\t":    cls = CLS_TAB;
            "-":     cls = CLS_MINUS;
            default: cls = (char_byte >= "0" && char_byte <= "9") ? CLS_DIGIT : CLS_OTHER;
         endcase
      end
   end

   always_comb begin
      line_in = line_ff;
      if (prev_nl_ff && line_ff != {LINE_BITS{1'b1}}) begin
         line_in = line_ff + 1'b1;
      end
      prev_nl_in = (cls == CLS_NEWLINE);
   end

   assign line_ext         = LW'(line_in);
   assign item.cls         = cls;
   assign item.char_byte   = char_byte;
   assign item.line_number = line_ext[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= '0;
         prev_nl_ff <= 1'b1;
      end else if (accept) begin
         line_ff    <= line_in;
         prev_nl_ff <= prev_nl_in;
      end
   end

endmodule

`default_nettype wire

>>> src/satp_item_queue.sv
// Short queue of classified characters between front end and parser.
// Depends on satp_pkg.
`default_nettype none

module satp_item_queue
   import satp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          not_empty,
   output item_type      head
);

   localparam int PW = $clog2(ITEM_DEPTH);
   localparam int CW = $clog2(ITEM_DEPTH + 1);

   item_type        slot_ff [ITEM_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in;
   logic [PW-1:0]   rp_ff, rp_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(ITEM_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rp_ff];

   always_comb begin
      wp_in    = push ? wp_ff + 1'b1 : wp_ff;
      rp_in    = pop ? rp_ff + 1'b1 : rp_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> src/satp_back.sv
// Parser back end: phase machine, keyword match and literal accumulation.
// Emits up to two results per character. Depends on satp_pkg.
`default_nettype none

module satp_back
   import satp_pkg::*;
#(
   parameter int LITERAL_BITS = LITERAL_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_valid,
   input  wire item_type item,
   input  wire logic     room,
   output logic          pop,
   output rsp_wr_type    wr
);

   localparam int PW = LITERAL_BITS + 4;
   localparam int VW = (LITERAL_BITS > 32) ? LITERAL_BITS : 32;

   phase_type             phase_ff, phase_in;
   logic [3:0]            kpos_ff, kpos_in;
   logic                  neg_ff, neg_in;
   logic [LITERAL_BITS-1:0] acc_ff, acc_in;
   logic                  fin_ff, fin_in;

   logic                  eof, digit, is_s, is_c, is_v;
   logic [3:0]            dval;
   logic [7:0]            ch;
   logic [PW-1:0]         prod;
   logic                  ovf;
   logic                  kw_known, kw_ok, kw_last;
   logic [3:0]            kw_len;
   logic [VW-1:0]         mag_ext, lit_full;
   logic signed [31:0]    lit_val;

   phase_type             sb_phase;
   logic                  sb_fail, sb_neg;
   err_type               sb_code;
   logic [LITERAL_BITS-1:0] sb_acc;

   assign pop   = item_valid && room;
   assign ch    = item.char_byte;
   assign eof   = (item.cls == CLS_EOF);
   assign digit = (item.cls == CLS_DIGIT);
   assign dval  = ch[3:0];
   assign is_s  = (item.cls == CLS_OTHER) && (ch == "s");
   assign is_c  = (item.cls == CLS_OTHER) && (ch == "c");
   assign is_v  = (item.cls == CLS_OTHER) && (ch == "v");

   assign prod = (PW'(acc_ff) << 3) + (PW'(acc_ff) << 1) + PW'(dval);
   assign ovf  = |prod[PW-1:LITERAL_BITS];

   assign kw_known = (phase_ff == PH_KW_KNOWN);
   assign kw_len   = kw_known ? KW_KNOWN_LEN : KW_SAT_LEN;
   assign kw_ok    = (kpos_ff < kw_len) && !eof && (ch == kw_char(kw_known, kpos_ff));
   assign kw_last  = (kpos_ff == kw_len - 4'd1);

   assign mag_ext  = VW'(acc_ff);
   assign lit_full = neg_ff ? -mag_ext : mag_ext;
   assign lit_val  = lit_full[31:0];

   always_comb begin
      sb_phase = phase_ff;
      sb_fail  = 1'b0;
      sb_code  = ERR_EXPECTED_LITERAL;
      sb_neg   = 1'b0;
      sb_acc   = '0;
      case (item.cls)
         CLS_EOF: begin
            sb_fail = 1'b1;
            sb_code = ERR_MISSING_ZERO;
         end
         CLS_SPACE, CLS_TAB: sb_phase = PH_BLANKS;
         CLS_NEWLINE:        sb_phase = PH_V_START;
         CLS_MINUS: begin
            sb_neg   = 1'b1;
            sb_phase = PH_MINUS;
         end
         CLS_DIGIT: begin
            sb_acc   = LITERAL_BITS'(dval);
            sb_phase = PH_DIGITS;
         end
         default: sb_fail = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      kpos_in  = kpos_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      fin_in   = fin_ff;
      if (pop && !fin_ff) begin
         case (phase_ff)
            PH_START: begin
               if (is_s)      phase_in = PH_S_SPACE;
               else if (is_c) phase_in = PH_COMMENT;
               else           fin_in   = 1'b1;
            end
            PH_COMMENT: begin
               if (eof)                          fin_in   = 1'b1;
               else if (item.cls == CLS_NEWLINE) phase_in = PH_START;
            end
            PH_S_SPACE: begin
               if (item.cls == CLS_SPACE) phase_in = PH_S_WORD;
               else                       fin_in   = 1'b1;
            end
            PH_S_WORD: begin
               kpos_in = '0;
               if (!eof && ch == "S")      phase_in = PH_KW_SAT;
               else if (!eof && ch == "U") phase_in = PH_U_N;
               else                        fin_in   = 1'b1;
            end
            PH_U_N: begin
               if (!eof && ch == "N") phase_in = PH_UN_X;
               else                   fin_in   = 1'b1;
            end
            PH_UN_X: begin
               kpos_in = '0;
               if (!eof && ch == "K")      phase_in = PH_KW_KNOWN;
               else if (!eof && ch == "S") phase_in = PH_KW_UNSAT;
               else                        fin_in   = 1'b1;
            end
            PH_KW_SAT, PH_KW_KNOWN, PH_KW_UNSAT: begin
               if (!kw_ok) begin
                  fin_in = 1'b1;
               end else if (kw_last) begin
                  kpos_in = '0;
                  if (phase_ff == PH_KW_SAT) phase_in = PH_V_START;
                  else                       fin_in   = 1'b1;
               end else begin
                  kpos_in = kpos_ff + 4'd1;
               end
            end
            PH_V_START: begin
               if (is_v) phase_in = PH_BLANKS;
               else      fin_in   = 1'b1;
            end
            PH_BLANKS: begin
               phase_in = sb_phase;
               neg_in   = sb_neg;
               acc_in   = sb_acc;
               fin_in   = sb_fail;
            end
            PH_MINUS: begin
               if (digit) begin
                  acc_in   = LITERAL_BITS'(dval);
                  phase_in = PH_DIGITS;
               end else begin
                  fin_in = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (digit) begin
                  if (ovf) fin_in = 1'b1;
                  else     acc_in = prod[LITERAL_BITS-1:0];
               end else if (acc_ff == '0) begin
                  fin_in = 1'b1;
               end else begin
                  phase_in = sb_phase;
                  neg_in   = sb_neg;
                  acc_in   = sb_acc;
                  fin_in   = sb_fail;
               end
            end
            default: fin_in = 1'b1;
         endcase
      end
   end

   // results
   always_comb begin
      logic    fail;
      err_type code;
      fail      = 1'b0;
      code      = ERR_INVALID_SOLUTION;
      wr.count  = 2'd0;
      wr.first  = mk_result(KIND_ERROR, '0, ERR_BAD_LINE_START, item.line_number, 1'b1);
      wr.second = mk_result(KIND_ERROR, '0, sb_code, item.line_number, 1'b1);
      if (pop && !fin_ff) begin
         case (phase_ff)
            PH_START: begin
               fail = !is_s && !is_c;
               code = ERR_BAD_LINE_START;
            end
            PH_COMMENT: begin
               fail = eof;
               code = ERR_NO_SOLUTION;
            end
            PH_S_SPACE:  fail = (item.cls != CLS_SPACE);
            PH_S_WORD:   fail = eof || (ch != "S" && ch != "U");
            PH_U_N:      fail = eof || (ch != "N");
            PH_UN_X:     fail = eof || (ch != "K" && ch != "S");
            PH_KW_SAT:   fail = !kw_ok;
            PH_KW_KNOWN, PH_KW_UNSAT: begin
               fail = !kw_ok || kw_last;
               code = kw_ok ? ERR_NOT_SATISFIABLE : ERR_INVALID_SOLUTION;
            end
            PH_V_START: begin
               fail = !is_v;
               code = ERR_MISSING_ZERO;
            end
            PH_BLANKS: begin
               fail = sb_fail;
               code = sb_code;
            end
            PH_MINUS: begin
               fail = !digit;
               code = ERR_EXPECTED_LITERAL;
            end
            PH_DIGITS: begin
               if (digit) begin
                  fail = ovf;
                  code = ERR_OVERFLOW;
               end else if (acc_ff == '0) begin
                  wr.count = 2'd1;
                  wr.first = mk_result(KIND_DONE, '0, ERR_BAD_LINE_START,
                                       item.line_number, 1'b1);
               end else begin
                  wr.count = sb_fail ? 2'd2 : 2'd1;
                  wr.first = mk_result(KIND_LITERAL, lit_val, ERR_BAD_LINE_START,
                                       item.line_number, !sb_fail);
               end
            end
            default: fail = 1'b1;
         endcase
         if (fail) begin
            wr.count = 2'd1;
            wr.first = mk_result(KIND_ERROR, '0, code, item.line_number, 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         kpos_ff  <= '0;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kpos_ff  <= kpos_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

`default_nettype wire

>>> src/satp_rsp_queue.sv
// Result queue: takes up to two results a cycle from the parser, hands one a cycle out while popped.
// Depends on satp_pkg.
`default_nettype none

module satp_rsp_queue
   import satp_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rsp_wr_type                    wr,
   input  wire logic                          pop,
   output logic                               room,
   output logic                               not_empty,
   output logic [$clog2(RSP_DEPTH+1)-1:0]     count,
   output result_type                         head
);

   localparam int PW = $clog2(RSP_DEPTH);
   localparam int CW = $clog2(RSP_DEPTH + 1);

   result_type    slot_ff [RSP_DEPTH];
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_next;
   logic [CW-1:0] count_ff, count_in;

   assign room      = (count_ff <= CW'(RSP_DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;
   assign head      = slot_ff[rp_ff];
   assign wp_next   = wp_ff + 1'b1;

   always_comb begin
      wp_in    = wp_ff + PW'(wr.count);
      rp_in    = pop ? rp_ff + 1'b1 : rp_ff;
      count_in = count_ff + CW'(wr.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         slot_ff[wp_ff] <= wr.first;
      end
      if (wr.count == 2'd2) begin
         slot_ff[wp_next] <= wr.second;
      end
   end

endmodule

`default_nettype wire

>>> tb/satp_result_checker.sv
// Result checker for the SAT solution text parser: watches both channels, predicts the
// literals, done marks and parse errors of each accepted character and compares them.
// Depends on satp_pkg for the phase, kind, error and result types.
module satp_result_checker
   import satp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [7:0]         req_char_byte,
   input  wire logic               req_end_of_file,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_kind,
   input  wire logic signed [31:0] rsp_literal_value,
   input  wire logic [2:0]         rsp_error_code,
   input  wire logic [15:0]        rsp_line_number,
   input  wire logic               rsp_last_of_run,
   output int                      fail_count,
   output int                      awaited,
   output int                      checked
);

   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [15:0] LINE_TOP = 16'hffff;
   localparam longint unsigned MAG_MAX = 64'h7fff_ffff;
   // error field reads zero outside errors
   localparam err_type CODE_NONE = ERR_BAD_LINE_START;

   string tail_satisfiable = "ATISFIABLE\n";
   string tail_unknown     = "NOWN\n";

   phase_type       phase;
   logic [3:0]      word_pos;
   logic            minus_seen;
   longint unsigned magnitude;
   logic [15:0]     line_count;
   logic            after_newline;
   logic            parse_over;

   result_type step_results[$];
   result_type awaited_results[$];

   task automatic push_result(input kind_type k, input logic signed [31:0] lit,
                              input err_type code);
      result_type r;
      r.kind          = k;
      r.literal_value = lit;
      r.error_code    = code;
      r.line_number   = line_count;
      r.last_of_run   = 1'b0;
      step_results.push_back(r);
   endtask

   task automatic raise_error(input err_type code);
      push_result(KIND_ERROR, 32'sd0, code);
      parse_over = 1'b1;
   endtask

   task automatic take_gap_char(input logic [7:0] c, input logic e);
      if (e) begin
         raise_error(ERR_MISSING_ZERO);
      end else if (c == CH_SPACE || c == CH_TAB) begin
         phase = PH_BLANKS;
      end else if (c == CH_NL) begin
         phase = PH_V_START;
      end else if (c == CH_MINUS) begin
         minus_seen = 1'b1;
         phase      = PH_MINUS;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         minus_seen = 1'b0;
         magnitude  = c - CH_ZERO;
         phase      = PH_DIGITS;
      end else begin
         raise_error(ERR_EXPECTED_LITERAL);
      end
   endtask

   task automatic match_word(input logic [7:0] c, input logic e, input string word,
                             input logic accepted);
      if (word_pos >= word.len() || e || c != word[word_pos]) begin
         raise_error(ERR_INVALID_SOLUTION);
      end else begin
         word_pos = word_pos + 4'd1;
         if (word_pos == word.len()) begin
            word_pos = 4'd0;
            if (accepted) begin
               phase = PH_V_START;
            end else begin
               raise_error(ERR_NOT_SATISFIABLE);
            end
         end
      end
   endtask

   task automatic predict_item(input logic [7:0] c, input logic e);
      logic              digit;
      longint unsigned   d;
      logic signed [31:0] value;
      result_type        r;
      digit = !e && c >= CH_ZERO && c <= CH_NINE;
      step_results.delete();
      if (!parse_over) begin
         if (after_newline && line_count != LINE_TOP) begin
            line_count = line_count + 16'd1;
         end
         after_newline = !e && c == CH_NL;
         case (phase)
            PH_START: begin
               if (!e && c == "s") phase = PH_S_SPACE;
               else if (!e && c == "c") phase = PH_COMMENT;
               else raise_error(ERR_BAD_LINE_START);
            end
            PH_COMMENT: begin
               if (e) raise_error(ERR_NO_SOLUTION);
               else if (c == CH_NL) phase = PH_START;
            end
            PH_S_SPACE: begin
               if (!e && c == CH_SPACE) phase = PH_S_WORD;
               else raise_error(ERR_INVALID_SOLUTION);
            end
            PH_S_WORD: begin
               word_pos = 4'd0;
               if (!e && c == "S") phase = PH_KW_SAT;
               else if (!e && c == "U") phase = PH_U_N;
               else raise_error(ERR_INVALID_SOLUTION);
            end
            PH_U_N: begin
               if (!e && c == "N") phase = PH_UN_X;
               else raise_error(ERR_INVALID_SOLUTION);
            end
            PH_UN_X: begin
               word_pos = 4'd0;
               if (!e && c == "K") phase = PH_KW_KNOWN;
               else if (!e && c == "S") phase = PH_KW_UNSAT;
               else raise_error(ERR_INVALID_SOLUTION);
            end
            PH_KW_SAT:   match_word(c, e, tail_satisfiable, 1'b1);
            PH_KW_KNOWN: match_word(c, e, tail_unknown, 1'b0);
            PH_KW_UNSAT: match_word(c, e, tail_satisfiable, 1'b0);
            PH_V_START: begin
               if (!e && c == "v") phase = PH_BLANKS;
               else raise_error(ERR_MISSING_ZERO);
            end
            PH_BLANKS: take_gap_char(c, e);
            PH_MINUS: begin
               if (digit) begin
                  magnitude = c - CH_ZERO;
                  phase     = PH_DIGITS;
               end else begin
                  raise_error(ERR_EXPECTED_LITERAL);
               end
            end
            PH_DIGITS: begin
               if (digit) begin
                  d = c - CH_ZERO;
                  if (magnitude > (MAG_MAX - d) / 10) raise_error(ERR_OVERFLOW);
                  else magnitude = magnitude * 10 + d;
               end else if (magnitude == 0) begin
                  push_result(KIND_DONE, 32'sd0, CODE_NONE);
                  parse_over = 1'b1;
               end else begin
                  value = magnitude[31:0];
                  if (minus_seen) value = -value;
                  push_result(KIND_LITERAL, value, CODE_NONE);
                  magnitude  = 0;
                  minus_seen = 1'b0;
                  take_gap_char(c, e);
               end
            end
            default: raise_error(ERR_INVALID_SOLUTION);
         endcase
         foreach (step_results[i]) begin
            r             = step_results[i];
            r.last_of_run = (i == step_results.size() - 1);
            awaited_results.push_back(r);
         end
      end
   endtask

   task automatic check_result();
      result_type want;
      checked++;
      if (awaited_results.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("unexpected result: kind %0d literal %0d code %0d line %0d last %0b",
                     rsp_kind, rsp_literal_value, rsp_error_code, rsp_line_number,
                     rsp_last_of_run);
         end
      end else begin
         want = awaited_results.pop_front();
         if (rsp_kind != want.kind || rsp_literal_value != want.literal_value ||
             rsp_error_code != want.error_code || rsp_line_number != want.line_number ||
             rsp_last_of_run != want.last_of_run) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("mismatch: expected kind %0d literal %0d code %0d line %0d last %0b",
                        want.kind, want.literal_value, want.error_code, want.line_number,
                        want.last_of_run);
               $display("          got      kind %0d literal %0d code %0d line %0d last %0b",
                        rsp_kind, rsp_literal_value, rsp_error_code, rsp_line_number,
                        rsp_last_of_run);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase         = PH_START;
         word_pos      = 4'd0;
         minus_seen    = 1'b0;
         magnitude     = 0;
         line_count    = 16'd0;
         after_newline = 1'b1;
         parse_over    = 1'b0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) predict_item(req_char_byte, req_end_of_file);
         if (rsp_valid && !rsp_stall) check_result();
      end
      awaited = awaited_results.size();
   end

endmodule

>>> tb/tb_sat_solution_text_parser_core.sv
// Testbench top for sat_solution_text_parser_core: drives one solution text per run with
// random comments, literal lines and a randomly chosen ending, and gives the verdict.
// Depends on satp_pkg, the parser core and satp_result_checker.
module tb_sat_solution_text_parser_core;
   import satp_pkg::*;

   typedef enum {
      END_BAD_START,
      END_EOF_AT_START,
      END_EOF_IN_COMMENT,
      END_BAD_S_SPACE,
      END_EOF_IN_S_LINE,
      END_BAD_S_WORD,
      END_BAD_UN,
      END_BAD_KEYWORD,
      END_NOT_SAT_UNKNOWN,
      END_NOT_SAT_UNSAT,
      END_ZERO_NEWLINE,
      END_ZERO_MINUS,
      END_ZERO_DOUBLE,
      END_ZERO_EOF,
      END_LITERAL_EOF,
      END_LITERAL_STRAY,
      END_MINUS_STRAY,
      END_OVERFLOW,
      END_EOF_BETWEEN,
      END_BAD_V_START,
      END_STRAY_BETWEEN
   } ending_type;

   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic [7:0]         req_char_byte   = 8'h00;
   logic               req_end_of_file = 1'b0;
   logic               rsp_stall       = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_literal_value;
   logic [2:0]         rsp_error_code;
   logic [15:0]        rsp_line_number;
   logic               rsp_last_of_run;

   int fail_count;
   int awaited;
   int checked;
   int items_sent    = 0;
   int newlines_sent = 0;
   int send_gap_pct  = 10;
   int recv_gap_pct  = 53;
   ending_type ending;

   sat_solution_text_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_literal_value (rsp_literal_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_line_number   (rsp_line_number),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   satp_result_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_literal_value (rsp_literal_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_line_number   (rsp_line_number),
      .rsp_last_of_run   (rsp_last_of_run),
      .fail_count        (fail_count),
      .awaited           (awaited),
      .checked           (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_gap_pct);
   end

   initial begin
      #10_000_000;
      $display("tb_sat_solution_text_parser_core: FAIL");
      $finish;
   end

   task automatic send_item(input logic [7:0] c, input logic e);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= c;
      req_end_of_file <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (!e && c == CH_NL) newlines_sent++;
      if (items_sent >= 840) begin
         send_gap_pct = 0;
         recv_gap_pct = 0;
      end else if (items_sent >= 420) begin
         send_gap_pct = 53;
         recv_gap_pct = 10;
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] stray_char();
      logic [7:0] c;
      c = CH_MINUS;
      while (c inside {CH_NL, CH_TAB, CH_SPACE, CH_MINUS, "c", "s", "v"} ||
             (c >= CH_ZERO && c <= CH_NINE)) begin
         c = $urandom_range(0, 255);
      end
      return c;
   endfunction

   function automatic string rand_gap();
      string g;
      g = "";
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 1)) g = {g, " "};
         else g = {g, "\t"};
      end
      return g;
   endfunction

   function automatic string rand_literal();
      longint unsigned m;
      string           s;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) m = $urandom_range(1, 20);
      else if (pick < 82) m = $urandom_range(21, 100000);
      else if (pick < 86) m = 64'h7fff_ffff;
      else m = $urandom_range(1, 32'h7fff_ffff);
      s = $sformatf("%0d", m);
      if ($urandom_range(0, 9) == 0) s = {"0", s};
      if ($urandom_range(0, 1)) s = {"-", s};
      return s;
   endfunction

   function automatic string rand_v_line();
      string s;
      int    tokens;
      s      = "v";
      tokens = $urandom_range(0, 8);
      for (int i = 0; i < tokens; i++) begin
         if (i > 0 || $urandom_range(0, 3) != 0) s = {s, rand_gap()};
         s = {s, rand_literal()};
      end
      if ($urandom_range(0, 2) == 0) s = {s, rand_gap()};
      return {s, "\n"};
   endfunction

   initial begin
      logic [7:0] c;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_text("c");
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b0);
      send_text("\n");
      repeat ($urandom_range(0, 3)) begin
         send_text("c");
         repeat ($urandom_range(0, 12)) begin
            c = CH_NL;
            while (c == CH_NL) c = $urandom_range(0, 255);
            send_item(c, 1'b0);
         end
         send_text("\n");
      end

      if ($urandom_range(0, 5) == 0) begin
         ending = ending_type'($urandom_range(END_BAD_START, END_NOT_SAT_UNSAT));
      end else begin
         send_text("s SATISFIABLE\n");
         send_text("v 2147483647\t-2147483647\n");
         send_text("v\n");
         while (items_sent < 1200) send_text(rand_v_line());
         ending = ending_type'($urandom_range(END_ZERO_NEWLINE, END_STRAY_BETWEEN));
      end

      case (ending)
         END_BAD_START:       send_item(stray_char(), 1'b0);
         END_EOF_AT_START:    send_item($urandom_range(0, 255), 1'b1);
         END_EOF_IN_COMMENT: begin
            send_text("c no answer");
            send_item($urandom_range(0, 255), 1'b1);
         end
         END_BAD_S_SPACE:     send_text("sX");
         END_EOF_IN_S_LINE: begin
            send_text("s ");
            send_item($urandom_range(0, 255), 1'b1);
         end
         END_BAD_S_WORD:      send_text("s Q");
         END_BAD_UN:          send_text("s UNX");
         END_BAD_KEYWORD:     send_text("s SATISFIABLE ");
         END_NOT_SAT_UNKNOWN: send_text("s UNKNOWN\n");
         END_NOT_SAT_UNSAT:   send_text("s UNSATISFIABLE\n");
         END_ZERO_NEWLINE:    send_text("v 3 0\n");
         END_ZERO_MINUS:      send_text("v -0 ");
         END_ZERO_DOUBLE:     send_text("v\t00\t");
         END_ZERO_EOF: begin
            send_text("v 0");
            send_item($urandom_range(0, 255), 1'b1);
         end
         END_LITERAL_EOF: begin
            send_text("v 17 -42");
            send_item($urandom_range(0, 255), 1'b1);
         end
         END_LITERAL_STRAY: begin
            send_text("v -9");
            send_item(stray_char(), 1'b0);
         end
         END_MINUS_STRAY: begin
            send_text("v 1 -");
            if ($urandom_range(0, 1)) send_item($urandom_range(0, 255), 1'b1);
            else send_item(stray_char(), 1'b0);
         end
         END_OVERFLOW: begin
            send_text({"v ", $sformatf("%0d", 64'd2147483648 + $urandom_range(0, 1000000))});
         end
         END_EOF_BETWEEN: begin
            send_text("v 5 ");
            send_item($urandom_range(0, 255), 1'b1);
         end
         END_BAD_V_START: begin
            send_text("v 5\n");
            if ($urandom_range(0, 1)) send_item($urandom_range(0, 255), 1'b1);
            else send_item(stray_char(), 1'b0);
         end
         default: begin
            send_text("v 5 ");
            send_item(stray_char(), 1'b0);
         end
      endcase

      // parser is finished now: drop these silently
      repeat (12) send_item($urandom_range(0, 255), $urandom_range(0, 1));
      while (items_sent < 1200) send_item($urandom_range(0, 255), $urandom_range(0, 1));
      req_valid <= 1'b0;

      while (awaited != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("summary: %0d input transactions (%0d newlines), %0d results checked",
               items_sent, newlines_sent, checked);
      $display("summary: stream ended with %s", ending.name());
      if (fail_count == 0) begin
         $display("tb_sat_solution_text_parser_core: PASS");
      end else begin
         $display("tb_sat_solution_text_parser_core: FAIL");
      end
      $finish;
   end

endmodule
